/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the graph traversal block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GTU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define GTU_ASSERT_IMP(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`else
`define GTU_ASSERT(lbl, clk, rst, prop)
`define GTU_ASSERT_IMP(lbl, clk, rst, cond, prop)
`endif
`endif

/* sv/gtu_pkg.sv */
// Shared constants and codes of the graph traversal block.
// No dependencies.
package gtu_pkg;
  localparam int VERTICES_DEF   = 16;
  localparam int MAX_DEGREE_DEF = 16;
  localparam int MAXV           = 16;
  localparam int VW_FIELD       = 4;
  localparam int VCOUNT_W       = 5;
  localparam int CFG_IDX_W      = 2;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
  localparam logic [1:0] CMD_TRAVERSE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 2'd1;
endpackage

/* sv/gtu_req_if.sv */
// Input channel of the graph traversal block.
// Depends on gtu_pkg.
interface gtu_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [gtu_pkg::VW_FIELD-1:0] source_vertex;
  logic [gtu_pkg::VW_FIELD-1:0] target_vertex;
  logic [gtu_pkg::VW_FIELD-1:0] start_vertex;
  modport source (output valid, command, source_vertex, target_vertex, start_vertex,
                  input ready);
  modport sink (input valid, command, source_vertex, target_vertex, start_vertex,
                output ready);
endinterface

/* sv/gtu_rsp_if.sv */
// Result channel of the graph traversal block.
// Depends on gtu_pkg.
interface gtu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gtu_pkg::VW_FIELD-1:0] vertex;
  logic                         last;
  logic [1:0]                   status;
  modport source (output valid, vertex, last, status, input ready);
  modport sink (input valid, vertex, last, status, output ready);
endinterface

/* sv/gtu_cfg_if.sv */
// Register write channel of the graph traversal block.
// Depends on gtu_pkg.
interface gtu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gtu_pkg::CFG_IDX_W-1:0] index;
  logic [gtu_pkg::VCOUNT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/graph_traversal_bfs_dfs_unit.sv */
// Graph traversal unit: per-vertex neighbor lists in a synchronous RAM, walked breadth-first
// or depth-first from a start vertex, emitting each reachable vertex once with the last flagged.
// A traversal is bounded by the neighbor RAM port: breadth-first reads one neighbor per cycle
// while scanning a vertex, and depth-first reads a neighbor in ST_DFS_TOP, checks it in
// ST_DFS_CHK and pops the stack in ST_DFS_TOP.
// Depends on gtu_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"
module graph_traversal_bfs_dfs_unit #(
  parameter int VERTICES   = gtu_pkg::VERTICES_DEF,
  parameter int MAX_DEGREE = gtu_pkg::MAX_DEGREE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gtu_cfg_if.sink    cfg,
  gtu_req_if.sink    req,
  gtu_rsp_if.source  rsp
);
  import gtu_pkg::*;

  localparam int NV    = (VERTICES < MAXV) ? VERTICES : MAXV;
  localparam int VW    = $clog2(NV);
  localparam int CW    = $clog2(MAX_DEGREE + 1);
  localparam int AW    = $clog2(NV * MAX_DEGREE);
  localparam int SW    = $clog2(MAXV);
  localparam int TW    = SW + 1;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_BFS_POP  = 6'b000010,
    ST_BFS_SCAN = 6'b000100,
    ST_DFS_TOP  = 6'b001000,
    ST_DFS_CHK  = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t                state;
  logic                  traversal_order;
  logic [VCOUNT_W-1:0]   vertex_count;
  logic [CW-1:0]         nbr_count [NV];
  logic                  visited [NV];
  logic [VW_FIELD-1:0]   work_list [MAXV];
  logic [CW-1:0]         level_cursor [MAXV];
  logic [TW-1:0]         list_head;
  logic [TW-1:0]         list_tail;
  logic [VW_FIELD-1:0]   cur_vertex;
  logic [CW-1:0]         cur_degree;
  logic [CW-1:0]         scan_idx;
  logic                  rd_pend;
  logic [VW_FIELD-1:0]   nbr_ram [NV*MAX_DEGREE];
  logic [VW_FIELD-1:0]   ram_q;
  logic                  pend_valid;
  logic [VW_FIELD-1:0]   pend_vertex;
  logic [1:0]            pend_status;
  logic                  out_valid;
  logic [VW_FIELD-1:0]   out_vertex;
  logic                  out_last;
  logic [1:0]            out_status;

  logic [VCOUNT_W-1:0]   n_act;
  logic                  can_emit;
  logic                  emit_ok;
  logic                  emit_req;
  logic                  accept;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic                  scan_issue;
  logic [SW-1:0]         top_lvl;
  logic [VW_FIELD-1:0]   top_vertex;
  logic [CW-1:0]         top_cursor;
  logic                  top_more;
  logic                  w_take;
  logic                  src_ok;
  logic                  dst_ok;
  logic                  start_ok;

  assign n_act    = (vertex_count > VCOUNT_W'(NV)) ? VCOUNT_W'(NV) : vertex_count;
  assign can_emit = !out_valid || rsp.ready;
  assign emit_ok  = !pend_valid || can_emit;
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.vertex = out_vertex;
  assign rsp.last   = out_last;
  assign rsp.status = out_status;

  assign src_ok   = {1'b0, req.source_vertex} < n_act;
  assign dst_ok   = {1'b0, req.target_vertex} < n_act;
  assign start_ok = {1'b0, req.start_vertex} < n_act;

  assign scan_issue = scan_idx < cur_degree;
  assign top_lvl    = SW'(list_tail - TW'(1));
  assign top_vertex = work_list[top_lvl];
  assign top_cursor = level_cursor[top_lvl];
  assign top_more   = (list_tail != '0) && (top_cursor < nbr_count[top_vertex[VW-1:0]]);
  assign w_take     = ({1'b0, ram_q} < n_act) && !visited[ram_q[VW-1:0]]
                      && !list_tail[SW];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    emit_req  = 1'b0;
    unique case (state)
      ST_BFS_POP: begin
        emit_req = (list_head < list_tail);
      end
      ST_BFS_SCAN: begin
        ram_re    = scan_issue;
        ram_raddr = AW'(cur_vertex[VW-1:0]) * AW'(MAX_DEGREE) + AW'(scan_idx);
      end
      ST_DFS_TOP: begin
        ram_re    = top_more;
        ram_raddr = AW'(top_vertex[VW-1:0]) * AW'(MAX_DEGREE) + AW'(top_cursor);
      end
      ST_DFS_CHK: begin
        emit_req = w_take;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && req.command == CMD_ADD_EDGE && src_ok && dst_ok &&
        nbr_count[req.source_vertex[VW-1:0]] < CW'(MAX_DEGREE)) begin
      nbr_ram[AW'(req.source_vertex[VW-1:0]) * AW'(MAX_DEGREE) +
              AW'(nbr_count[req.source_vertex[VW-1:0]])] <= req.target_vertex;
    end
    if (ram_re) begin
      ram_q <= nbr_ram[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      traversal_order <= 1'b0;
      vertex_count    <= VCOUNT_W'(16);
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_ORDER) begin
        traversal_order <= cfg.data[0];
      end else if (cfg.index == REG_VCOUNT) begin
        vertex_count <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && can_emit) begin
      out_valid <= 1'b1;
    end else if (emit_req && emit_ok && pend_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_FINISH && can_emit) begin
      out_vertex <= pend_vertex;
      out_status <= pend_status;
      out_last   <= 1'b1;
    end else if (emit_req && emit_ok && pend_valid) begin
      out_vertex <= pend_vertex;
      out_status <= pend_status;
      out_last   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      rd_pend    <= 1'b0;
      list_head  <= '0;
      list_tail  <= '0;
      for (int k = 0; k < NV; k++) begin
        nbr_count[k] <= '0;
        visited[k]   <= 1'b0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority if (req.command == CMD_CLEAR) begin
              for (int k = 0; k < NV; k++) begin
                nbr_count[k] <= '0;
              end
              pend_vertex <= '0;
              pend_status <= STATUS_OK;
              pend_valid  <= 1'b1;
              state       <= ST_FINISH;
            end else if (req.command == CMD_ADD_EDGE) begin
              pend_vertex <= '0;
              pend_valid  <= 1'b1;
              state       <= ST_FINISH;
              if (!src_ok || !dst_ok) begin
                pend_status <= STATUS_RANGE;
              end else if (nbr_count[req.source_vertex[VW-1:0]] >= CW'(MAX_DEGREE)) begin
                pend_status <= STATUS_FULL;
              end else begin
                pend_status <= STATUS_OK;
                nbr_count[req.source_vertex[VW-1:0]] <=
                  nbr_count[req.source_vertex[VW-1:0]] + CW'(1);
              end
            end else if (req.command == CMD_TRAVERSE) begin
              if (!start_ok) begin
                pend_vertex <= '0;
                pend_status <= STATUS_RANGE;
                pend_valid  <= 1'b1;
                state       <= ST_FINISH;
              end else begin
                for (int k = 0; k < NV; k++) begin
                  visited[k] <= (k == int'(req.start_vertex));
                end
                work_list[0] <= req.start_vertex;
                list_tail    <= TW'(1);
                if (traversal_order) begin
                  level_cursor[0] <= '0;
                  pend_vertex     <= req.start_vertex;
                  pend_status     <= STATUS_OK;
                  pend_valid      <= 1'b1;
                  state           <= ST_DFS_TOP;
                end else begin
                  list_head <= '0;
                  state     <= ST_BFS_POP;
                end
              end
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_BFS_POP: begin
          if (!emit_req) begin
            state <= ST_FINISH;
          end else if (emit_ok) begin
            cur_vertex  <= work_list[list_head[SW-1:0]];
            cur_degree  <= nbr_count[work_list[list_head[SW-1:0]][VW-1:0]];
            scan_idx    <= '0;
            rd_pend     <= 1'b0;
            list_head   <= list_head + TW'(1);
            pend_vertex <= work_list[list_head[SW-1:0]];
            pend_status <= STATUS_OK;
            pend_valid  <= 1'b1;
            state       <= ST_BFS_SCAN;
          end
        end
        ST_BFS_SCAN: begin
          if (scan_issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          rd_pend <= scan_issue;
          if (rd_pend && w_take) begin
            visited[ram_q[VW-1:0]]       <= 1'b1;
            work_list[list_tail[SW-1:0]] <= ram_q;
            list_tail                    <= list_tail + TW'(1);
          end
          if (!scan_issue && !rd_pend) begin
            state <= ST_BFS_POP;
          end
        end
        ST_DFS_TOP: begin
          if (list_tail == '0) begin
            state <= ST_FINISH;
          end else if (top_more) begin
            level_cursor[top_lvl] <= top_cursor + CW'(1);
            state                 <= ST_DFS_CHK;
          end else begin
            list_tail <= list_tail - TW'(1);
          end
        end
        ST_DFS_CHK: begin
          if (!w_take) begin
            state <= ST_DFS_TOP;
          end else if (emit_ok) begin
            visited[ram_q[VW-1:0]]          <= 1'b1;
            work_list[list_tail[SW-1:0]]    <= ram_q;
            level_cursor[list_tail[SW-1:0]] <= '0;
            list_tail                       <= list_tail + TW'(1);
            pend_vertex                     <= ram_q;
            pend_status                     <= STATUS_OK;
            pend_valid                      <= 1'b1;
            state                           <= ST_DFS_TOP;
          end
        end
        ST_FINISH: begin
          if (can_emit) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GTU_ASSERT_IMP(a_finish_has_word, clk, rst, state == ST_FINISH, pend_valid)
  `GTU_ASSERT_IMP(a_idle_no_word, clk, rst, state == ST_IDLE, !pend_valid)
  `GTU_ASSERT(a_tail_bound, clk, rst, list_tail <= TW'(MAXV))
  `GTU_ASSERT_IMP(a_head_le_tail, clk, rst,
                  state == ST_BFS_POP || state == ST_BFS_SCAN, list_head <= list_tail)
endmodule

/* test/graph_traversal_bfs_dfs_unit_tb.sv */
// Testbench for graph_traversal_bfs_dfs_unit: drives clear, add-edge, traverse and unused
// command words and register writes with random idling, predicts every visit word in a scoreboard
// and compares field by field. Depends on gtu_pkg, the channel interfaces and the RTL of the block.
module graph_traversal_bfs_dfs_unit_tb;
  import gtu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [3:0] vertex;
    logic       last;
    logic [1:0] status;
  } visit_word_t;

  class traversal_scoreboard;
    logic       order;
    logic [4:0] vcount;
    logic [3:0] adjacency[16][16];
    int         degree[16];
    visit_word_t pending[$];
    int         mismatches;

    function void clear_state();
      order = 1'b0;
      vcount = 5'd16;
      for (int i = 0; i < 16; i++) degree[i] = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] data);
      if (idx == REG_ORDER) order = data[0];
      else if (idx == REG_VCOUNT) vcount = data;
    endfunction

    function void push_word(logic [3:0] v, logic l, logic [1:0] s);
      visit_word_t w;
      w.vertex = v;
      w.last = l;
      w.status = s;
      pending.push_back(w);
    endfunction

    function void note_word(logic [1:0] cmd, logic [3:0] src, logic [3:0] dst,
                            logic [3:0] start);
      int n;
      bit seen[16];
      logic [3:0] walk[$];
      logic [3:0] stack_v[16];
      int stack_c[16];
      int depth;
      int u;
      int w;
      n = (vcount > 16) ? 16 : int'(vcount);
      case (cmd)
        CMD_CLEAR: begin
          for (int i = 0; i < 16; i++) degree[i] = 0;
          push_word(4'd0, 1'b1, STATUS_OK);
        end
        CMD_ADD_EDGE: begin
          if (src >= n || dst >= n) begin
            push_word(4'd0, 1'b1, STATUS_RANGE);
          end else if (degree[src] >= 16) begin
            push_word(4'd0, 1'b1, STATUS_FULL);
          end else begin
            adjacency[src][degree[src]] = dst;
            degree[src]++;
            push_word(4'd0, 1'b1, STATUS_OK);
          end
        end
        CMD_TRAVERSE: begin
          if (start >= n) begin
            push_word(4'd0, 1'b1, STATUS_RANGE);
          end else begin
            for (int i = 0; i < 16; i++) seen[i] = 1'b0;
            seen[start] = 1'b1;
            if (!order) begin
              walk.push_back(start);
              for (int h = 0; h < walk.size(); h++) begin
                u = int'(walk[h]);
                for (int i = 0; i < degree[u]; i++) begin
                  w = int'(adjacency[u][i]);
                  if (w < n && !seen[w]) begin
                    seen[w] = 1'b1;
                    walk.push_back(4'(w));
                  end
                end
              end
            end else begin
              walk.push_back(start);
              stack_v[0] = start;
              stack_c[0] = 0;
              depth = 1;
              while (depth > 0) begin
                u = int'(stack_v[depth-1]);
                if (stack_c[depth-1] < degree[u]) begin
                  w = int'(adjacency[u][stack_c[depth-1]]);
                  stack_c[depth-1]++;
                  if (w < n && !seen[w] && depth < 16) begin
                    seen[w] = 1'b1;
                    walk.push_back(4'(w));
                    stack_v[depth] = 4'(w);
                    stack_c[depth] = 0;
                    depth++;
                  end
                end else begin
                  depth--;
                end
              end
            end
            foreach (walk[i]) push_word(walk[i], i == walk.size() - 1, STATUS_OK);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [3:0] v, logic l, logic [1:0] s);
      visit_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: vertex %0d last %0b status %0d", v, l, s);
        return;
      end
      exp_w = pending.pop_front();
      if (exp_w.vertex !== v || exp_w.last !== l || exp_w.status !== s) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected vertex %0d last %0b status %0d, got %0d %0b %0d",
                   exp_w.vertex, exp_w.last, exp_w.status, v, l, s);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_rsp;
  int   stall_cycles;
  traversal_scoreboard board;

  gtu_cfg_if cfg_ch ();
  gtu_req_if req_ch ();
  gtu_rsp_if rsp_ch ();

  graph_traversal_bfs_dfs_unit DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_word(rsp_ch.vertex, rsp_ch.last, rsp_ch.status);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [3:0] src, logic [3:0] dst,
                           logic [3:0] start);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.source_vertex <= src;
    req_ch.target_vertex <= dst;
    req_ch.start_vertex <= start;
    do @(posedge clk); while (!req_ch.ready);
    board.note_word(cmd, src, dst, start);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int n;
    int pick;
    n = int'(board.vcount);
    if ($urandom_range(0, 1) == 0)
      send_word(CMD_CLEAR, 4'($urandom), 4'($urandom), 4'($urandom));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_word(CMD_ADD_EDGE,
                  4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, n-1)),
                  4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, n-1)),
                  4'($urandom));
      else if (pick < 82)
        send_word(CMD_TRAVERSE, 4'($urandom), 4'($urandom),
                  4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, n-1)));
      else if (pick < 86)
        send_word(CMD_CLEAR, 4'($urandom), 4'($urandom), 4'($urandom));
      else
        send_word(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    int vcounts[10] = '{16, 16, 5, 1, 16, 9, 3, 16, 12, 7};
    board = new();
    board.clear_state();
    quiet = 1'b0;
    hold_rsp = 1'b0;
    rst = 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ORDER;
    cfg_ch.data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_CLEAR;
    req_ch.source_vertex <= '0;
    req_ch.target_vertex <= '0;
    req_ch.start_vertex <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd15);
    send_word(CMD_ADD_EDGE, 4'd0, 4'd1, 4'd0);
    send_word(CMD_ADD_EDGE, 4'd0, 4'd15, 4'd0);
    send_word(CMD_ADD_EDGE, 4'd1, 4'd3, 4'd0);
    send_word(CMD_ADD_EDGE, 4'd15, 4'd3, 4'd0);
    send_word(CMD_ADD_EDGE, 4'd3, 4'd0, 4'd0);
    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd0);
    send_word(CMD_UNUSED, 4'd15, 4'd15, 4'd15);
    write_reg(REG_ORDER, 5'd1);
    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd0);
    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd3);
    write_reg(REG_VCOUNT, 5'd4);
    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd0);
    send_word(CMD_ADD_EDGE, 4'd5, 4'd1, 4'd0);
    send_word(CMD_ADD_EDGE, 4'd1, 4'd9, 4'd0);
    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd9);
    send_word(CMD_CLEAR, 4'd0, 4'd0, 4'd0);
    write_reg(REG_VCOUNT, 5'd16);
    for (int i = 0; i < 17; i++) send_word(CMD_ADD_EDGE, 4'd2, i[3:0], 4'd0);
    send_word(CMD_TRAVERSE, 4'd0, 4'd0, 4'd2);

    for (int p = 0; p < 10; p++) begin
      write_reg(REG_ORDER, 5'(p % 2));
      write_reg(REG_VCOUNT, 5'(vcounts[p]));
      if (p == 2) hold_rsp = 1'b1;
      if (p >= 8) quiet = 1'b1;
      random_phase(25);
    end

    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
